/* hdl/scc_pkg.sv */
package scc_pkg;

    // group masks, bit0 A, bit1 B, bit2 C, bit3 D
    localparam logic [3:0] GRP_A   = 4'b0001;
    localparam logic [3:0] GRP_B   = 4'b0010;
    localparam logic [3:0] GRP_C   = 4'b0100;
    localparam logic [3:0] GRP_D   = 4'b1000;
    localparam logic [3:0] GRP_AB  = 4'b0011;
    localparam logic [3:0] GRP_CD  = 4'b1100;
    localparam logic [3:0] GRP_ALL = 4'b1111;

    // register reset values
    localparam logic [5:0] PREP_RESET = 6'd10;
    localparam logic [5:0] STEP_RESET = 6'd30;

    // configuration register indexes
    localparam logic CFG_PREP_SECONDS  = 1'b0;
    localparam logic CFG_DURATION_STEP = 1'b1;

    // item kinds
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_KEY  = 1'b1;

    // key function codes
    localparam logic [3:0] KEY_NONE     = 4'd0;
    localparam logic [3:0] KEY_DUR1     = 4'd1;
    localparam logic [3:0] KEY_DUR2     = 4'd2;
    localparam logic [3:0] KEY_DUR3     = 4'd3;
    localparam logic [3:0] KEY_DUR4     = 4'd4;
    localparam logic [3:0] KEY_DUR5     = 4'd5;
    localparam logic [3:0] KEY_DUR6     = 4'd6;
    localparam logic [3:0] KEY_TOG_A    = 4'd7;
    localparam logic [3:0] KEY_TOG_B    = 4'd8;
    localparam logic [3:0] KEY_TOG_C    = 4'd9;
    localparam logic [3:0] KEY_TOG_D    = 4'd10;
    localparam logic [3:0] KEY_TOG_AB   = 4'd11;
    localparam logic [3:0] KEY_TOG_CD   = 4'd12;
    localparam logic [3:0] KEY_TOG_ALL  = 4'd13;
    localparam logic [3:0] KEY_START    = 4'd14;
    localparam logic [3:0] KEY_RESET    = 4'd15;

    typedef struct packed {
        logic       busy;
        logic       run;
        logic [8:0] round_length;
        logic [8:0] remaining;
        logic [5:0] prep_left;
        logic [3:0] groups;
    } scc_state_t;

    typedef struct packed {
        logic       busy_res;
        logic       running;
        logic       in_prep;
        logic [8:0] shown_seconds;
        logic [3:0] group_mask;
        logic       round_ended;
    } scc_result_t;

    // keypad position to function code
    function automatic logic [3:0] key_code(input logic [3:0] key_index);
        logic [3:0] code;
        case (key_index)
            4'd0:    code = KEY_DUR1;
            4'd1:    code = KEY_DUR2;
            4'd2:    code = KEY_DUR3;
            4'd3:    code = KEY_START;
            4'd4:    code = KEY_DUR4;
            4'd5:    code = KEY_DUR5;
            4'd6:    code = KEY_DUR6;
            4'd7:    code = KEY_RESET;
            4'd8:    code = KEY_TOG_AB;
            4'd9:    code = KEY_TOG_CD;
            4'd10:   code = KEY_TOG_ALL;
            4'd11:   code = KEY_NONE;
            4'd12:   code = KEY_TOG_A;
            4'd13:   code = KEY_TOG_B;
            4'd14:   code = KEY_TOG_C;
            default: code = KEY_TOG_D;
        endcase
        return code;
    endfunction

    // clear all bits if any is set, else set all
    function automatic logic [3:0] toggle_groups(input logic [3:0] g, input logic [3:0] bits);
        logic [3:0] r;
        if ((g & bits) != 4'b0000) begin
            r = g & ~bits;
        end else begin
            r = g | bits;
        end
        return r;
    endfunction

    // only exact AB and CD are exchanged
    function automatic logic [3:0] swap_groups(input logic [3:0] g);
        logic [3:0] r;
        if (g == GRP_AB) begin
            r = GRP_CD;
        end else if (g == GRP_CD) begin
            r = GRP_AB;
        end else begin
            r = g;
        end
        return r;
    endfunction

endpackage

/* hdl/scc_step.sv */
module scc_step
    import scc_pkg::*;
(
    input  scc_state_t  cur,
    input  logic        action,
    input  logic [3:0]  key_index,
    input  logic        link_ok,
    input  logic [5:0]  prep_seconds,
    input  logic [5:0]  duration_step,
    output scc_state_t  nxt,
    output scc_result_t res
);

    logic [3:0] code;
    logic [8:0] product;
    logic       ended;

    assign code    = key_code(key_index);
    assign product = {5'b00000, code} * {3'b000, duration_step};

    // next state for one item
    always_comb begin
        nxt   = cur;
        ended = 1'b0;
        if (action == ACT_KEY) begin
            if (link_ok) begin
                if (!cur.busy) begin
                    case (code)
                        KEY_DUR1, KEY_DUR2, KEY_DUR3,
                        KEY_DUR4, KEY_DUR5, KEY_DUR6: begin
                            nxt.round_length = product;
                            nxt.remaining    = product;
                        end
                        KEY_TOG_A:   nxt.groups = toggle_groups(cur.groups, GRP_A);
                        KEY_TOG_B:   nxt.groups = toggle_groups(cur.groups, GRP_B);
                        KEY_TOG_C:   nxt.groups = toggle_groups(cur.groups, GRP_C);
                        KEY_TOG_D:   nxt.groups = toggle_groups(cur.groups, GRP_D);
                        KEY_TOG_AB:  nxt.groups = toggle_groups(cur.groups, GRP_AB);
                        KEY_TOG_CD:  nxt.groups = toggle_groups(cur.groups, GRP_CD);
                        KEY_TOG_ALL: nxt.groups = toggle_groups(cur.groups, GRP_ALL);
                        KEY_START: begin
                            nxt.run  = 1'b1;
                            nxt.busy = 1'b1;
                        end
                        KEY_RESET: begin
                            nxt.round_length = 9'd0;
                            nxt.remaining    = 9'd0;
                            nxt.prep_left    = prep_seconds;
                        end
                        default: begin
                        end
                    endcase
                end else if (code == KEY_START) begin
                    nxt.run = !cur.run;
                end else if (code == KEY_RESET && !cur.run) begin
                    // reload while stopped
                    nxt.remaining = cur.round_length;
                    nxt.prep_left = prep_seconds;
                    nxt.groups    = swap_groups(cur.groups);
                    nxt.busy      = 1'b0;
                end
            end
        end else if (cur.busy && cur.run) begin
            // tick while running
            if (cur.remaining == 9'd0) begin
                nxt.run       = 1'b0;
                nxt.remaining = cur.round_length;
                nxt.prep_left = prep_seconds;
                nxt.groups    = swap_groups(cur.groups);
                nxt.busy      = 1'b0;
                ended         = 1'b1;
            end else if (cur.prep_left == 6'd0) begin
                nxt.remaining = cur.remaining - 9'd1;
            end else begin
                nxt.prep_left = cur.prep_left - 6'd1;
            end
        end
    end

    // status seen after the item
    always_comb begin
        res.busy_res      = nxt.busy;
        res.running       = nxt.run;
        res.in_prep       = nxt.busy && (nxt.prep_left != 6'd0);
        res.shown_seconds = res.in_prep ? {3'b000, nxt.prep_left} : nxt.remaining;
        res.group_mask    = nxt.groups;
        res.round_ended   = ended;
    end

endmodule

/* hdl/shot_clock_countdown_controller_core.sv */
// Shot clock countdown controller: every item (a one-second tick or a keypad
// press) yields exactly one status item. An item is taken in every cycle
// while the result register is empty or being drained, and its status
// appears on the m_ side in the cycle after acceptance; the single registered
// state-update stage sets this rate of one item per clock. Configuration
// writes take effect at the next duration key, reload or idle reset, not on a running count.
module shot_clock_countdown_controller_core
    import scc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [5:0] cfg_wdata,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [3:0] s_key_index,
    input  logic       s_link_ok,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_busy_res,
    output logic       m_running,
    output logic       m_in_prep,
    output logic [8:0] m_shown_seconds,
    output logic [3:0] m_group_mask,
    output logic       m_round_ended
);

    logic [5:0]  prep_seconds_reg;
    logic [5:0]  duration_step_reg;
    scc_state_t  state_reg;
    scc_state_t  state_next;
    scc_result_t result_reg;
    scc_result_t result_next;
    logic        m_valid_reg;
    logic        accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_seconds_reg  <= PREP_RESET;
            duration_step_reg <= STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PREP_SECONDS:  prep_seconds_reg  <= cfg_wdata;
                CFG_DURATION_STEP: duration_step_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    scc_step u_step (
        .cur           (state_reg),
        .action        (s_action),
        .key_index     (s_key_index),
        .link_ok       (s_link_ok),
        .prep_seconds  (prep_seconds_reg),
        .duration_step (duration_step_reg),
        .nxt           (state_next),
        .res           (result_next)
    );

    // controller state, updated once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.busy         <= 1'b0;
            state_reg.run          <= 1'b0;
            state_reg.round_length <= 9'd0;
            state_reg.remaining    <= 9'd0;
            state_reg.prep_left    <= PREP_RESET;
            state_reg.groups       <= GRP_ALL;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_busy_res      = result_reg.busy_res;
    assign m_running       = result_reg.running;
    assign m_in_prep       = result_reg.in_prep;
    assign m_shown_seconds = result_reg.shown_seconds;
    assign m_group_mask    = result_reg.group_mask;
    assign m_round_ended   = result_reg.round_ended;

`ifndef SYNTH
    // the clock only runs inside a round
    a_run_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.run |-> state_reg.busy)
        else $error("run flag set while idle");

    // state moves only with an accepted item
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("state changed without an item");

    // a round end leaves the block idle and stopped
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.round_ended) |-> (!result_reg.busy_res && !result_reg.running))
        else $error("round ended but still busy");

    // prep is shown only inside a round
    a_prep_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.in_prep) |-> result_reg.busy_res)
        else $error("prep shown while idle");

    // result mirrors the state it was taken from
    a_result_groups: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (result_reg.group_mask == state_reg.groups
                    && result_reg.busy_res == state_reg.busy))
        else $error("result does not match state");
`endif

endmodule

/* tb/sv/shot_clock_countdown_controller_core_tb.sv */
module shot_clock_countdown_controller_core_tb;
    import scc_pkg::*;

    // keypad positions, row times four plus column
    localparam logic [3:0] KP_DUR1   = 4'd0;
    localparam logic [3:0] KP_DUR2   = 4'd1;
    localparam logic [3:0] KP_DUR3   = 4'd2;
    localparam logic [3:0] KP_START  = 4'd3;
    localparam logic [3:0] KP_DUR4   = 4'd4;
    localparam logic [3:0] KP_DUR5   = 4'd5;
    localparam logic [3:0] KP_DUR6   = 4'd6;
    localparam logic [3:0] KP_RESET  = 4'd7;
    localparam logic [3:0] KP_TOG_AB = 4'd8;
    localparam logic [3:0] KP_TOG_CD = 4'd9;
    localparam logic [3:0] KP_TOG_4  = 4'd10;
    localparam logic [3:0] KP_SPARE  = 4'd11;
    localparam logic [3:0] KP_TOG_A  = 4'd12;
    localparam logic [3:0] KP_TOG_B  = 4'd13;
    localparam logic [3:0] KP_TOG_C  = 4'd14;
    localparam logic [3:0] KP_TOG_D  = 4'd15;

    localparam int unsigned PHASE_ITEMS = 165;

    // status prediction and comparison
    class shot_clock_scoreboard;
        bit          busy;
        bit          run;
        logic [8:0]  round_len;
        logic [8:0]  remain;
        logic [5:0]  prep_left;
        logic [3:0]  groups;
        logic [5:0]  prep_cfg;
        logic [5:0]  step_cfg;
        logic [3:0]  keymap [16];
        scc_result_t expected_status [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned rounds_over;

        function new();
            keymap = '{KEY_DUR1, KEY_DUR2, KEY_DUR3, KEY_START,
                       KEY_DUR4, KEY_DUR5, KEY_DUR6, KEY_RESET,
                       KEY_TOG_AB, KEY_TOG_CD, KEY_TOG_ALL, KEY_NONE,
                       KEY_TOG_A, KEY_TOG_B, KEY_TOG_C, KEY_TOG_D};
            prep_cfg    = PREP_RESET;
            step_cfg    = STEP_RESET;
            busy        = 1'b0;
            run         = 1'b0;
            round_len   = '0;
            remain      = '0;
            prep_left   = PREP_RESET;
            groups      = GRP_ALL;
            mismatches  = 0;
            checked     = 0;
            rounds_over = 0;
        endfunction

        function void write_reg(logic idx, logic [5:0] value);
            if (idx == CFG_PREP_SECONDS) begin
                prep_cfg = value;
            end else begin
                step_cfg = value;
            end
        endfunction

        // any bit set clears the whole group, else sets it
        function void flip_groups(logic [3:0] bits);
            if ((groups & bits) != 4'b0000) begin
                groups = groups & ~bits;
            end else begin
                groups = groups | bits;
            end
        endfunction

        // end of round or reset while stopped: reload and exchange exact AB and CD
        function void reload();
            remain    = round_len;
            prep_left = prep_cfg;
            if (groups == GRP_AB) begin
                groups = GRP_CD;
            end else if (groups == GRP_CD) begin
                groups = GRP_AB;
            end
            busy = 1'b0;
        endfunction

        function void note_item(logic action, logic [3:0] key, logic link);
            logic [3:0]  code;
            logic        ended;
            scc_result_t status;
            ended = 1'b0;
            code  = keymap[key];
            if (action == ACT_KEY) begin
                if (link && !busy) begin
                    if (code >= KEY_DUR1 && code <= KEY_DUR6) begin
                        round_len = {5'b00000, code} * {3'b000, step_cfg};
                        remain    = round_len;
                    end else begin
                        case (code)
                            KEY_TOG_A:   flip_groups(GRP_A);
                            KEY_TOG_B:   flip_groups(GRP_B);
                            KEY_TOG_C:   flip_groups(GRP_C);
                            KEY_TOG_D:   flip_groups(GRP_D);
                            KEY_TOG_AB:  flip_groups(GRP_AB);
                            KEY_TOG_CD:  flip_groups(GRP_CD);
                            KEY_TOG_ALL: flip_groups(GRP_ALL);
                            KEY_START: begin
                                run  = 1'b1;
                                busy = 1'b1;
                            end
                            KEY_RESET: begin
                                round_len = '0;
                                remain    = '0;
                                prep_left = prep_cfg;
                            end
                            default: ;
                        endcase
                    end
                end else if (link) begin
                    if (code == KEY_START) begin
                        run = !run;
                    end else if (code == KEY_RESET && !run) begin
                        reload();
                    end
                end
            end else if (busy && run) begin
                // a zero countdown ends the round even in preparation
                if (remain == 0) begin
                    run   = 1'b0;
                    reload();
                    ended = 1'b1;
                end else if (prep_left == 0) begin
                    remain = remain - 9'd1;
                end else begin
                    prep_left = prep_left - 6'd1;
                end
            end
            status.busy_res      = busy;
            status.running       = run;
            status.in_prep       = busy && (prep_left != 0);
            status.shown_seconds = status.in_prep ? {3'b000, prep_left} : remain;
            status.group_mask    = groups;
            status.round_ended   = ended;
            if (ended) begin
                rounds_over++;
            end
            expected_status.push_back(status);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_status(scc_result_t got);
            scc_result_t want;
            if (expected_status.size() == 0) begin
                $error("status item arrived with nothing expected");
                mismatches++;
            end else begin
                want = expected_status.pop_front();
                checked++;
                compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                compare_field("running", 32'(want.running), 32'(got.running));
                compare_field("in_prep", 32'(want.in_prep), 32'(got.in_prep));
                compare_field("shown_seconds", 32'(want.shown_seconds),
                              32'(got.shown_seconds));
                compare_field("group_mask", 32'(want.group_mask), 32'(got.group_mask));
                compare_field("round_ended", 32'(want.round_ended),
                              32'(got.round_ended));
            end
        endfunction
    endclass

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       cfg_wr_en       = 1'b0;
    logic       cfg_index       = CFG_PREP_SECONDS;
    logic [5:0] cfg_wdata       = '0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic       s_action        = ACT_TICK;
    logic [3:0] s_key_index     = '0;
    logic       s_link_ok       = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_busy_res;
    logic       m_running;
    logic       m_in_prep;
    logic [8:0] m_shown_seconds;
    logic [3:0] m_group_mask;
    logic       m_round_ended;

    shot_clock_scoreboard sb = new();
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned items_sent  = 0;
    int unsigned settings    = 0;

    shot_clock_countdown_controller_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_key_index     (s_key_index),
        .s_link_ok       (s_link_ok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_busy_res      (m_busy_res),
        .m_running       (m_running),
        .m_in_prep       (m_in_prep),
        .m_shown_seconds (m_shown_seconds),
        .m_group_mask    (m_group_mask),
        .m_round_ended   (m_round_ended)
    );

    always #10 aclk = ~aclk;

    // status side: check accepted items, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_status(scc_result_t'({m_busy_res, m_running, m_in_prep,
                                           m_shown_seconds, m_group_mask,
                                           m_round_ended}));
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // one item through the input channel, with random gaps ahead of it
    task automatic send_item(logic action, logic [3:0] key, logic link);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= action;
        s_key_index <= key;
        s_link_ok   <= link;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(action, key, link);
        items_sent++;
    endtask

    // hold the sender until every status item is back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_status.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_config(logic [5:0] prep, logic [5:0] step);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PREP_SECONDS;
        cfg_wdata <= prep;
        @(posedge aclk);
        sb.write_reg(CFG_PREP_SECONDS, prep);
        cfg_index <= CFG_DURATION_STEP;
        cfg_wdata <= step;
        @(posedge aclk);
        sb.write_reg(CFG_DURATION_STEP, step);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings++;
    endtask

    // setup keys, start, then ticks mixed with stop, reset and noise
    task automatic play_round();
        logic [3:0]  group_keys [7] = '{KP_TOG_AB, KP_TOG_CD, KP_TOG_4, KP_TOG_A,
                                        KP_TOG_B, KP_TOG_C, KP_TOG_D};
        logic [3:0]  dur_keys [6]   = '{KP_DUR1, KP_DUR2, KP_DUR3,
                                        KP_DUR4, KP_DUR5, KP_DUR6};
        int unsigned pick;
        repeat ($urandom_range(3)) begin
            send_item(ACT_KEY, group_keys[$urandom_range(6)], 1'b1);
        end
        if ($urandom_range(9) == 0) begin
            send_item(ACT_KEY, KP_RESET, 1'b1);
        end
        // short rounds mostly
        if ($urandom_range(99) < 70) begin
            send_item(ACT_KEY, KP_DUR1, 1'b1);
        end else begin
            send_item(ACT_KEY, dur_keys[$urandom_range(5)], 1'b1);
        end
        send_item(ACT_KEY, KP_START, 1'b1);
        while (sb.busy) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_item(ACT_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
            end else if (pick < 82) begin
                send_item(ACT_KEY, KP_START, 1'b1);
            end else if (pick < 86) begin
                send_item(ACT_KEY, KP_RESET, 1'b1);
            end else if (pick < 92) begin
                send_item(ACT_KEY, 4'($urandom_range(15)), 1'b1);
            end else begin
                send_item(ACT_KEY, 4'($urandom_range(15)), 1'b0);
            end
        end
    endtask

    task automatic run_phase(int unsigned budget);
        int unsigned first;
        bit          paused;
        first  = items_sent;
        paused = 1'b0;
        while (items_sent - first < budget) begin
            if ($urandom_range(99) < 80) begin
                play_round();
            end else begin
                send_item(1'($urandom_range(1)), 4'($urandom_range(15)),
                          1'($urandom_range(1)));
            end
            if (!paused && items_sent - first >= budget / 2) begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    // run limit
    initial begin
        #4000000;
        $display("** shot_clock_countdown_controller_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int unsigned ph_idle  [5] = '{0, 55, 0, 11, 0};
        int unsigned ph_stall [5] = '{0, 0, 55, 11, 0};
        logic [5:0]  ph_prep  [5] = '{6'd3, 6'd0, 6'd63, 6'd5, 6'd1};
        logic [5:0]  ph_step  [5] = '{6'd2, 6'd1, 6'd63, 6'd0, 6'd60};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset register values, every key, edge cases
        send_item(ACT_TICK, 4'd0, 1'b0);
        send_item(ACT_KEY, KP_SPARE, 1'b1);
        send_item(ACT_KEY, KP_DUR1, 1'b0);
        send_item(ACT_KEY, KP_TOG_A, 1'b1);
        send_item(ACT_KEY, KP_TOG_B, 1'b1);
        send_item(ACT_KEY, KP_TOG_C, 1'b1);
        send_item(ACT_KEY, KP_TOG_D, 1'b1);
        send_item(ACT_KEY, KP_TOG_AB, 1'b1);
        // start with zero countdown, first tick ends it during prep
        send_item(ACT_KEY, KP_START, 1'b1);
        send_item(ACT_TICK, 4'd15, 1'b1);
        send_item(ACT_KEY, KP_TOG_CD, 1'b1);
        send_item(ACT_KEY, KP_TOG_4, 1'b1);
        send_item(ACT_KEY, KP_TOG_AB, 1'b1);
        send_item(ACT_KEY, KP_DUR6, 1'b1);
        send_item(ACT_KEY, KP_DUR5, 1'b1);
        send_item(ACT_KEY, KP_DUR4, 1'b1);
        send_item(ACT_KEY, KP_DUR3, 1'b1);
        send_item(ACT_KEY, KP_DUR2, 1'b1);
        send_item(ACT_KEY, KP_RESET, 1'b1);
        send_item(ACT_KEY, KP_DUR1, 1'b1);
        send_item(ACT_KEY, KP_START, 1'b1);
        send_item(ACT_TICK, 4'd0, 1'b0);
        // reset while running and other keys while busy are ignored
        send_item(ACT_KEY, KP_RESET, 1'b1);
        send_item(ACT_KEY, KP_TOG_B, 1'b1);
        send_item(ACT_KEY, KP_START, 1'b1);
        send_item(ACT_TICK, 4'd0, 1'b1);
        send_item(ACT_KEY, KP_RESET, 1'b1);
        drain();

        // random phases, each with its own register setting, some with idling or stalls
        for (int p = 0; p < 5; p++) begin
            idle_pct  = ph_idle[p];
            stall_pct = ph_stall[p];
            set_config(ph_prep[p], ph_step[p]);
            run_phase(PHASE_ITEMS);
        end

        repeat (10) @(posedge aclk);
        if (sb.expected_status.size() != 0) begin
            $error("%0d status items never arrived", sb.expected_status.size());
            sb.mismatches++;
        end
        $display("ran %0d items under %0d register settings with mixed idling",
                 items_sent, settings);
        $display("checked %0d status items, %0d rounds ran out at zero",
                 sb.checked, sb.rounds_over);
        if (sb.mismatches == 0) begin
            $display("** shot_clock_countdown_controller_core: PASSED **");
        end else begin
            $display("** shot_clock_countdown_controller_core: FAILED **");
        end
        $finish;
    end

endmodule
